// ----- hw/rtl/circular_queue_with_scans_assert.svh -----
// Assertion macros used by the RTL of the circular queue (included by cqs_back).
`ifndef CIRCULAR_QUEUE_WITH_SCANS_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_SCANS_ASSERT_SVH

`ifndef ASSERT_OFF
`define CQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CQS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CQS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/cqs_pkg.sv -----
`default_nettype none

package cqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int OCC_W   = 5;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_ENQ  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MAX  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EVEN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REPL = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] REPL_WORD = -32'sd1;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_MAX,
        OP_EVEN,
        OP_REPL,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [WORD_W-1:0] data;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } out_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] data;
    } cmd_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cqs_front.sv -----
`default_nettype none

module cqs_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cqs_pkg::in_t  s_item,
    output logic               push_valid,
    input  wire logic          push_ready,
    output cqs_pkg::cmd_t      push_cmd
);

    logic          cmd_valid_reg;
    logic          cmd_valid_next;
    cqs_pkg::cmd_t cmd_reg;
    cqs_pkg::cmd_t cmd_next;
    cqs_pkg::op_t  op_decoded;

    always_comb begin
        unique case (s_item.action)
            cqs_pkg::ACT_ENQ:  op_decoded = cqs_pkg::OP_ENQ;
            cqs_pkg::ACT_DEQ:  op_decoded = cqs_pkg::OP_DEQ;
            cqs_pkg::ACT_MAX:  op_decoded = cqs_pkg::OP_MAX;
            cqs_pkg::ACT_EVEN: op_decoded = cqs_pkg::OP_EVEN;
            cqs_pkg::ACT_REPL: op_decoded = cqs_pkg::OP_REPL;
            default:           op_decoded = cqs_pkg::OP_NOP;
        endcase
    end

    assign s_ready    = !cmd_valid_reg || push_ready;
    assign push_valid = cmd_valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
            cmd_next.op    = op_decoded;
            cmd_next.data  = s_item.data;
        end else if (push_ready) begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cqs_cmd_queue.sv -----
`default_nettype none

module cqs_cmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire cqs_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output cqs_pkg::cmd_t      pop_cmd
);

    cqs_pkg::cmd_t                 entry_reg [cqs_pkg::Q_DEPTH];
    logic [cqs_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [cqs_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [cqs_pkg::QCNT_W-1:0]    fill_reg;
    logic                          do_push;
    logic                          do_pop;

    function automatic logic [cqs_pkg::QPTR_W-1:0] qwrap(
        input logic [cqs_pkg::QPTR_W-1:0] p);
        if (p == cqs_pkg::QPTR_W'(cqs_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign push_ready = fill_reg != cqs_pkg::QCNT_W'(cqs_pkg::Q_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= qwrap(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= qwrap(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cqs_back.sv -----
`default_nettype none

`include "circular_queue_with_scans_assert.svh"

module cqs_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire cqs_pkg::cmd_t cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cqs_pkg::out_t      m_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [cqs_pkg::IDX_W-1:0]          head_reg, head_next;
    logic [cqs_pkg::IDX_W-1:0]          tail_reg, tail_next;
    logic [cqs_pkg::CNT_W-1:0]          count_reg, count_next;
    cqs_pkg::op_t                       op_reg, op_next;
    logic [cqs_pkg::IDX_W-1:0]          ptr_reg, ptr_next;
    logic [cqs_pkg::IDX_W-1:0]          pend_addr_reg, pend_addr_next;
    logic [cqs_pkg::CNT_W-1:0]          left_reg, left_next;
    logic                               first_reg, first_next;
    logic signed [cqs_pkg::WORD_W-1:0]  acc_reg, acc_next;
    logic                               out_valid_reg, out_valid_next;
    cqs_pkg::out_t                      out_item_reg, out_item_next;

    logic signed [cqs_pkg::WORD_W-1:0]  mem [cqs_pkg::DEPTH];
    logic signed [cqs_pkg::WORD_W-1:0]  rd_data_reg;
    logic [cqs_pkg::IDX_W-1:0]          rd_addr;
    logic                               mem_we;
    logic [cqs_pkg::IDX_W-1:0]          mem_wa;
    logic signed [cqs_pkg::WORD_W-1:0]  mem_wd;
    logic                               out_free;
    logic                               is_empty;
    logic                               is_full;

    assign out_free  = !out_valid_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign is_empty  = count_reg == '0;
    assign is_full   = count_reg == cqs_pkg::CNT_W'(cqs_pkg::DEPTH);
    assign rd_addr   = (state_reg == S_SCAN) ? ptr_reg : head_reg;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        left_next      = left_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mem_we         = 1'b0;
        mem_wa         = tail_reg;
        mem_wd         = cmd.data;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    op_next        = cmd.op;
                    ptr_next       = cqs_pkg::wrap_inc(head_reg);
                    pend_addr_next = head_reg;
                    left_next      = count_reg - 1'b1;
                    first_next     = 1'b1;
                    acc_next       = '0;
                    out_item_next.value     = '0;
                    out_item_next.status    = cqs_pkg::ST_OK;
                    out_item_next.occupancy = cqs_pkg::to_occ(count_reg);
                    case (cmd.op) inside
                        cqs_pkg::OP_ENQ: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_item_next.status = cqs_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                tail_next  = cqs_pkg::wrap_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                                out_item_next.occupancy = cqs_pkg::to_occ(count_next);
                            end
                        end
                        cqs_pkg::OP_DEQ: begin
                            if (is_empty) begin
                                out_valid_next       = 1'b1;
                                out_item_next.status = cqs_pkg::ST_EMPTY;
                            end else begin
                                head_next  = cqs_pkg::wrap_inc(head_reg);
                                count_next = count_reg - 1'b1;
                                left_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        cqs_pkg::OP_MAX: begin
                            if (is_empty) begin
                                out_valid_next       = 1'b1;
                                out_item_next.status = cqs_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        cqs_pkg::OP_EVEN, cqs_pkg::OP_REPL: begin
                            if (is_empty) begin
                                out_valid_next = 1'b1;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (op_reg)
                    cqs_pkg::OP_DEQ: begin
                        acc_next = rd_data_reg;
                    end
                    cqs_pkg::OP_MAX: begin
                        if (first_reg || (rd_data_reg > acc_reg)) begin
                            acc_next = rd_data_reg;
                        end
                    end
                    cqs_pkg::OP_EVEN: begin
                        if (!rd_data_reg[0]) begin
                            acc_next = acc_reg + rd_data_reg;
                        end
                    end
                    cqs_pkg::OP_REPL: begin
                        if (rd_data_reg[0]) begin
                            mem_we = 1'b1;
                            mem_wa = pend_addr_reg;
                            mem_wd = cqs_pkg::REPL_WORD;
                        end
                    end
                    default: begin
                    end
                endcase
                first_next = 1'b0;
                if (left_reg != '0) begin
                    pend_addr_next = ptr_reg;
                    ptr_next       = cqs_pkg::wrap_inc(ptr_reg);
                    left_next      = left_reg - 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_item_next.value     = acc_reg;
                    out_item_next.status    = cqs_pkg::ST_OK;
                    out_item_next.occupancy = cqs_pkg::to_occ(count_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        left_reg      <= left_next;
        first_reg     <= first_next;
        acc_reg       <= acc_next;
        out_item_reg  <= out_item_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CQS_ASSERT(a_count_bound, aclk, aresetn,
        count_reg <= cqs_pkg::CNT_W'(cqs_pkg::DEPTH), "occupancy above depth")
    `CQS_ASSERT(a_scan_write_repl, aclk, aresetn,
        (state_reg == S_SCAN && mem_we) |-> (op_reg == cqs_pkg::OP_REPL),
        "store written during a non-replacing scan")
    `CQS_ASSERT(a_deq_count, aclk, aresetn,
        (cmd_valid && cmd_ready && cmd.op == cqs_pkg::OP_DEQ && !is_empty)
        |=> (count_reg == $past(count_reg) - 1'b1), "dequeue did not lower occupancy")
    `CQS_ASSERT(a_no_pop_busy, aclk, aresetn,
        (state_reg != S_IDLE) |-> !cmd_ready, "command taken while a scan is running")

endmodule

`default_nettype wire

// ----- hw/rtl/circular_queue_with_scans.sv -----
`default_nettype none

// Circular FIFO of signed 32-bit words with scan actions. Each input beat carries
// one action and yields exactly one result beat with a value, a status and the
// occupancy after the action. Beats first pass an input register and a two-entry
// command queue. The execution unit answers enqueue, unused action codes and
// actions that find the queue empty straight from its idle state; dequeue, max, even
// sum and odd replacement pass through a scan state and then a finish state. New
// commands are taken only when idle. Scans are bound by the
// single read port of the word store, which delivers one registered word a cycle.
// The store needs no initialization after reset.
module circular_queue_with_scans (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cqs_pkg::in_t  s_item,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cqs_pkg::out_t      m_item
);

    logic          push_valid;
    logic          push_ready;
    cqs_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    cqs_pkg::cmd_t pop_cmd;

    cqs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cqs_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    cqs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
